// ===== src/glu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GCD/LCM package
// Shared constants and the queue control type for the GCD and LCM unit.
// ----------------------------------------------------------------------------
package glu_pkg;

  localparam int unsigned OperandBitsDef = 31;
  localparam int unsigned QueueDepthDef  = 2;

  typedef struct packed {
    logic push;
    logic full;
  } glu_qctl_t;

endpackage
`default_nettype wire

// ===== src/glu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GCD/LCM item queue
// Two-entry queue that decouples the front from the arithmetic back end.
// ----------------------------------------------------------------------------
module glu_queue #(
  parameter int unsigned Width = 63
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  glu_pkg::glu_qctl_t ctl_i,
  input  wire  [Width-1:0] wdata_i,
  output logic             full_o,
  output logic             valid_o,
  input  wire              pop_i,
  output logic [Width-1:0] rdata_o
);
  import glu_pkg::*;

  logic [Width-1:0] mem_q [2];
  logic             wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = ctl_i.push && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/glu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GCD/LCM front end
// Accepts operand items, flags zero operands and pushes them into the queue.
// ----------------------------------------------------------------------------
module glu_front #(
  parameter int unsigned OperandBits = 31
) (
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire  [OperandBits-1:0]  first_value_i,
  input  wire  [OperandBits-1:0]  second_value_i,
  input  wire                     full_i,
  output glu_pkg::glu_qctl_t      ctl_o,
  output logic [2*OperandBits:0]  entry_o
);
  import glu_pkg::*;

  logic zero_op;

  assign zero_op    = (first_value_i == '0) || (second_value_i == '0);
  assign in_ready_o = !full_i;
  assign ctl_o.push = in_valid_i && !full_i;
  assign ctl_o.full = full_i;
  assign entry_o    = {zero_op, first_value_i, second_value_i};

endmodule
`default_nettype wire

// ===== src/glu_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GCD/LCM back end
// Binary GCD, restoring division of the first operand by the GCD and one
// multiply by the second operand, with a registered result.
// ----------------------------------------------------------------------------
module glu_core #(
  parameter int unsigned OperandBits = 31
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       q_valid_i,
  input  wire  [2*OperandBits:0]    q_data_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic [OperandBits-1:0]    common_divisor_o,
  output logic [2*OperandBits-1:0]  common_multiple_o
);
  import glu_pkg::*;

  localparam int unsigned N  = OperandBits;
  localparam int unsigned KW = $clog2(N + 1);
  localparam int unsigned CW = $clog2(N);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStrip = 3'd1;
  localparam logic [2:0] StRun   = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StMul   = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [N-1:0]   a_q, a_d, b_q, b_d, x_q, x_d, y_q, y_d, g_q, g_d, qt_q, qt_d;
  logic [N:0]     rem_q, rem_d, rem_sh;
  logic [KW-1:0]  k_q, k_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           out_valid_q, out_valid_d;
  logic [N-1:0]   div_q, div_d;
  logic [2*N-1:0] mul_q, mul_d;
  logic           zero_op;
  logic [N-1:0]   op_a, op_b;
  logic           rem_ge;

  assign {zero_op, op_a, op_b} = q_data_i;
  assign rem_sh = {rem_q[N-1:0], a_q[N-1]};
  assign rem_ge = (rem_sh >= {1'b0, g_q});
  assign q_pop_o = (state_q == StIdle) && q_valid_i;

  always_comb begin
    state_d     = state_q;
    a_d = a_q; b_d = b_q; x_d = x_q; y_d = y_q; g_d = g_q; qt_d = qt_q;
    rem_d = rem_q; k_d = k_q; cnt_d = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_d = div_q; mul_d = mul_q;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          a_d = op_a; b_d = op_b; x_d = op_a; y_d = op_b; k_d = '0;
          if (zero_op) begin
            g_d = op_a | op_b; qt_d = '0; state_d = StMul;
          end else begin
            state_d = StStrip;
          end
        end
      end
      StStrip: begin
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1; y_d = y_q >> 1; k_d = k_q + 1'b1;
        end else begin
          state_d = StRun;
        end
      end
      StRun: begin
        priority if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (y_q == '0) begin
          g_d = x_q << k_q; rem_d = '0; qt_d = '0;
          cnt_d = CW'(N - 1); state_d = StDiv;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q > y_q) begin
          x_d = y_q; y_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
      end
      StDiv: begin
        rem_d = rem_ge ? (rem_sh - {1'b0, g_q}) : rem_sh;
        qt_d  = {qt_q[N-2:0], rem_ge};
        a_d   = a_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StMul;
        end
      end
      StMul: begin
        if (!out_valid_q || out_ready_i) begin
          div_d = g_q;
          mul_d = (2*N)'(qt_q) * (2*N)'(b_q);
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; x_q <= x_d; y_q <= y_d; g_q <= g_d; qt_q <= qt_d;
    rem_q <= rem_d; k_q <= k_d; cnt_q <= cnt_d; div_q <= div_d; mul_q <= mul_d;
  end

  assign out_valid_o       = out_valid_q;
  assign common_divisor_o  = div_q;
  assign common_multiple_o = mul_q;

endmodule
`default_nettype wire

// ===== src/gcd_lcm_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The binary GCD loop takes one shift or subtract per cycle, and the restoring divider
// follows it. The back end takes no new item until it has registered its result; a
// two-entry queue takes new items meanwhile.
// Zero operands skip the GCD loop and the divider.
// Reset is asynchronous and active low; it empties the queue and the result.
// ----------------------------------------------------------------------------
// GCD/LCM unit top level
// Front end, item queue and arithmetic back end.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
  parameter int unsigned OperandBits = glu_pkg::OperandBitsDef
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  [OperandBits-1:0]    first_value_i,
  input  wire  [OperandBits-1:0]    second_value_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic [OperandBits-1:0]    common_divisor_o,
  output logic [2*OperandBits-1:0]  common_multiple_o
);
  import glu_pkg::*;

  glu_qctl_t               qctl;
  logic                    q_full, q_valid, q_pop;
  logic [2*OperandBits:0]  q_wdata, q_rdata;

  glu_front #(.OperandBits(OperandBits)) u_front (
    .in_valid_i, .in_ready_o, .first_value_i, .second_value_i,
    .full_i(q_full), .ctl_o(qctl), .entry_o(q_wdata)
  );

  glu_queue #(.Width(2*OperandBits+1)) u_queue (
    .clk_i, .rst_ni, .ctl_i(qctl), .wdata_i(q_wdata), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .rdata_o(q_rdata)
  );

  glu_core #(.OperandBits(OperandBits)) u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_rdata), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .common_divisor_o, .common_multiple_o
  );

endmodule
`default_nettype wire

// ===== src/glu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GCD/LCM port checker
// Checks results seen on the top-level ports.
// ----------------------------------------------------------------------------
module glu_checker #(
  parameter int unsigned OperandBits = 31
) (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      out_valid_o,
  input wire                      out_ready_i,
  input wire [OperandBits-1:0]    common_divisor_o,
  input wire [2*OperandBits-1:0]  common_multiple_o
);
  import glu_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(common_multiple_o)
      && $stable(common_divisor_o))
    else $error("Stalled result item changed.");

  a_gcd_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (common_multiple_o != '0) |-> common_divisor_o != '0)
    else $error("Nonzero multiple with zero divisor.");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (common_multiple_o != '0) |->
      common_multiple_o >= (2*OperandBits)'(common_divisor_o))
    else $error("Multiple below divisor.");

endmodule

bind gcd_lcm_unit glu_checker #(.OperandBits(OperandBits)) u_glu_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .common_divisor_o, .common_multiple_o
);
`default_nettype wire
